/* rtl/core/slcd_pkg.sv */
// Shared types, constants and digit tables for the segment LCD multiplex driver.
package slcd_pkg;

  localparam int NumCommons  = 4;
  localparam int NumSegments = 16;

  localparam int PhaseCount = 2 * NumCommons;
  localparam int PhaseW     = $clog2(PhaseCount);
  localparam int ComIdxW    = (NumCommons > 1) ? $clog2(NumCommons) : 1;
  localparam int ComDriveW  = 2 * NumCommons;
  localparam int SegDriveW  = 2 * NumSegments;

  // fixed field widths of the word
  localparam int ReqW    = 3;
  localparam int SegBitW = 16;
  localparam int ComSelW = 2;
  localparam int NumberW = 16;

  // number split: saturated value, hundreds digit, remainder below 100
  localparam int SatW   = 10;
  localparam int DigitW = 4;
  localparam int RemW   = 7;
  localparam logic [SatW-1:0] NumMax = SatW'(999);

  // digit pin positions
  localparam int PinHundOne = 1;
  localparam int PinTensOne = 3;
  localparam int PinOnesOne = 5;
  localparam int PinOnesTwo = 7;
  localparam int PinTensTwo = 9;

  // configuration port
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 32;
  localparam logic RegDisplayEnable = 1'b0;

  typedef enum logic [ReqW-1:0] {
    REQ_TICK    = 3'd0,
    REQ_CLEAR   = 3'd1,
    REQ_ICON    = 3'd2,
    REQ_NUM_ONE = 3'd3,
    REQ_NUM_TWO = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    LVL_GND        = 2'd0,
    LVL_THIRD      = 2'd1,
    LVL_TWO_THIRDS = 2'd2,
    LVL_FULL       = 2'd3
  } lvl_t;

  typedef logic [NumCommons-1:0][NumSegments-1:0] frame_t;

  typedef struct packed {
    req_t                   req;
    logic [NumSegments-1:0] bits;
    logic [ComSelW-1:0]     com;
    logic [DigitW-1:0]      hund;
    logic [RemW-1:0]        rem;
  } item_t;

  function automatic logic [7:0] digit_code_one(input logic [DigitW-1:0] d);
    logic [7:0] code;
    case (d)
      4'd0:    code = 8'h5F;
      4'd1:    code = 8'h50;
      4'd2:    code = 8'h3D;
      4'd3:    code = 8'h79;
      4'd4:    code = 8'h72;
      4'd5:    code = 8'h6B;
      4'd6:    code = 8'h6F;
      4'd7:    code = 8'h51;
      4'd8:    code = 8'h7F;
      4'd9:    code = 8'h7B;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

  function automatic logic [7:0] digit_code_two(input logic [DigitW-1:0] d);
    logic [7:0] code;
    case (d)
      4'd0:    code = 8'hFA;
      4'd1:    code = 8'h0A;
      4'd2:    code = 8'hBC;
      4'd3:    code = 8'h9E;
      4'd4:    code = 8'h4E;
      4'd5:    code = 8'hD6;
      4'd6:    code = 8'hF6;
      4'd7:    code = 8'h8A;
      4'd8:    code = 8'hFE;
      4'd9:    code = 8'hDE;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

  // segment bits a digit code lights on one common: low nibble at pin, high nibble at pin+1
  function automatic logic [NumSegments-1:0] digit_seg(input logic [7:0] code,
                                                       input int pin,
                                                       input int com);
    logic [31:0] w;
    logic [1:0]  ci;
    w  = '0;
    ci = 2'(com);
    if (com < 4) begin
      w[5'(pin)]     = code[{1'b0, ci}];
      w[5'(pin + 1)] = code[{1'b1, ci}];
    end
    return w[NumSegments-1:0];
  endfunction

endpackage

/* rtl/core/slcd_in_if.sv */
// Request channel: valid/ready handshake with the request word.
interface slcd_in_if;
  logic                                valid;
  logic                                ready;
  logic [slcd_pkg::ReqW-1:0]           req_type;
  logic [slcd_pkg::SegBitW-1:0]        seg_bits;
  logic [slcd_pkg::ComSelW-1:0]        com_select;
  logic [slcd_pkg::NumberW-1:0]        number;

  modport source (output valid, output req_type, output seg_bits, output com_select,
                  output number, input ready);
  modport sink   (input valid, input req_type, input seg_bits, input com_select,
                  input number, output ready);
endinterface

/* rtl/core/slcd_out_if.sv */
// Drive channel: valid/ready handshake with the drive level word.
interface slcd_out_if;
  logic                                valid;
  logic                                ready;
  logic [slcd_pkg::ComDriveW-1:0]      com_drive;
  logic [slcd_pkg::SegDriveW-1:0]      seg_drive;
  logic [slcd_pkg::PhaseW-1:0]         scan_phase;

  modport source (output valid, output com_drive, output seg_drive, output scan_phase,
                  input ready);
  modport sink   (input valid, input com_drive, input seg_drive, input scan_phase,
                  output ready);
endinterface

/* rtl/core/slcd_cfg.sv */
// APB-style configuration register block holding the display enable.
module slcd_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [slcd_pkg::CfgAddrW-1:0]  cfg_paddr,
  input  logic [slcd_pkg::CfgDataW-1:0]  cfg_pwdata,
  output logic [slcd_pkg::CfgDataW-1:0]  cfg_prdata,
  output logic                           cfg_pready,
  output logic                           display_enable
);

  logic enable_r;
  logic enable_nxt;
  logic sel_enable;

  assign cfg_pready = 1'b1;
  // word address: bit 2 selects the register, byte offset ignored
  assign sel_enable = (cfg_paddr[2] == slcd_pkg::RegDisplayEnable);

  always_comb begin
    enable_nxt = enable_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && sel_enable) begin
      enable_nxt = cfg_pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
    end else begin
      enable_r <= enable_nxt;
    end
  end

  assign cfg_prdata     = sel_enable ? {{(slcd_pkg::CfgDataW-1){1'b0}}, enable_r} : '0;
  assign display_enable = enable_r;

endmodule

/* rtl/core/slcd_in_stage.sv */
// Input register: captures a request word and splits off the hundreds digit.
module slcd_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  slcd_in_if.sink         in_ch,
  input  logic            take,
  output logic            item_valid,
  output slcd_pkg::item_t item
);

  logic                              valid_r;
  slcd_pkg::item_t                   item_r;
  slcd_pkg::item_t                   item_nxt;
  logic [slcd_pkg::SatW-1:0]         sat;
  logic [15:0]                       hund_prod;
  logic [slcd_pkg::DigitW-1:0]       hund;
  logic [slcd_pkg::SatW-1:0]         rem_full;
  logic [31:0]                       bits_wide;

  assign in_ch.ready = !valid_r || take;

  always_comb begin
    if (in_ch.number > slcd_pkg::NumberW'(slcd_pkg::NumMax)) begin
      sat = slcd_pkg::NumMax;
    end else begin
      sat = in_ch.number[slcd_pkg::SatW-1:0];
    end
    // divide by 100 as multiply by 41/4096, exact below 1000
    hund_prod = {6'b0, sat} * 16'd41;
    hund      = hund_prod[15:12];
    rem_full  = sat - ({6'b0, hund} * 10'd100);
    bits_wide = 32'(in_ch.seg_bits);

    item_nxt.req  = slcd_pkg::req_t'(in_ch.req_type);
    item_nxt.bits = bits_wide[slcd_pkg::NumSegments-1:0];
    item_nxt.com  = in_ch.com_select;
    item_nxt.hund = hund;
    item_nxt.rem  = rem_full[slcd_pkg::RemW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r <= item_nxt;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

/* rtl/core/slcd_frame.sv */
// Frame buffer: clear, icon OR and number rendering through the digit tables.
module slcd_frame (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  slcd_pkg::item_t  item,
  output slcd_pkg::frame_t frame
);

  slcd_pkg::frame_t              frame_r;
  slcd_pkg::frame_t              frame_nxt;
  logic [14:0]                   tens_prod;
  logic [slcd_pkg::DigitW-1:0]   tens;
  logic [slcd_pkg::RemW-1:0]     ones_full;
  logic [slcd_pkg::DigitW-1:0]   ones;
  logic [7:0]                    code_h1;
  logic [7:0]                    code_t1;
  logic [7:0]                    code_o1;
  logic [7:0]                    code_t2;
  logic [7:0]                    code_o2;

  always_comb begin
    // divide by 10 as multiply by 205/2048, exact below 100
    tens_prod = {8'b0, item.rem} * 15'd205;
    tens      = tens_prod[14:11];
    ones_full = item.rem - ({3'b0, tens} * 7'd10);
    ones      = ones_full[slcd_pkg::DigitW-1:0];

    code_h1 = slcd_pkg::digit_code_one(item.hund);
    code_t1 = slcd_pkg::digit_code_one(tens);
    code_o1 = slcd_pkg::digit_code_one(ones);
    code_t2 = slcd_pkg::digit_code_two(tens);
    code_o2 = slcd_pkg::digit_code_two(ones);

    frame_nxt = frame_r;
    case (item.req)
      slcd_pkg::REQ_CLEAR: begin
        frame_nxt = '0;
      end
      slcd_pkg::REQ_ICON: begin
        for (int c = 0; c < slcd_pkg::NumCommons; c++) begin
          if (32'(item.com) == c) begin
            frame_nxt[c] = frame_r[c] | item.bits;
          end
        end
      end
      slcd_pkg::REQ_NUM_ONE: begin
        for (int c = 0; c < slcd_pkg::NumCommons; c++) begin
          frame_nxt[c] = frame_r[c]
                       | slcd_pkg::digit_seg(code_h1, slcd_pkg::PinHundOne, c)
                       | slcd_pkg::digit_seg(code_t1, slcd_pkg::PinTensOne, c)
                       | slcd_pkg::digit_seg(code_o1, slcd_pkg::PinOnesOne, c);
        end
      end
      slcd_pkg::REQ_NUM_TWO: begin
        for (int c = 0; c < slcd_pkg::NumCommons; c++) begin
          frame_nxt[c] = frame_r[c]
                       | slcd_pkg::digit_seg(code_o2, slcd_pkg::PinOnesTwo, c)
                       | slcd_pkg::digit_seg(code_t2, slcd_pkg::PinTensTwo, c);
        end
      end
      default: begin
        frame_nxt = frame_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r <= '0;
    end else if (fire) begin
      frame_r <= frame_nxt;
    end
  end

  assign frame = frame_r;

endmodule

/* rtl/core/slcd_scan.sv */
// Scan phase counter, drive level generation and the output register.
module slcd_scan (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             tick_fire,
  input  slcd_pkg::frame_t frame,
  output logic             out_free,
  slcd_out_if.source       out_ch
);

  logic [slcd_pkg::PhaseW-1:0]    phase_r;
  logic [slcd_pkg::PhaseW-1:0]    phase_nxt;
  logic [slcd_pkg::ComIdxW-1:0]   active;
  logic                           odd;
  logic [slcd_pkg::NumSegments-1:0] word;
  logic [slcd_pkg::ComDriveW-1:0] com_drive_nxt;
  logic [slcd_pkg::SegDriveW-1:0] seg_drive_nxt;
  logic                           out_valid_r;
  logic [slcd_pkg::ComDriveW-1:0] com_drive_r;
  logic [slcd_pkg::SegDriveW-1:0] seg_drive_r;
  logic [slcd_pkg::PhaseW-1:0]    scan_phase_r;

  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    if (phase_r == slcd_pkg::PhaseW'(slcd_pkg::PhaseCount - 1)) begin
      phase_nxt = '0;
    end else begin
      phase_nxt = phase_r + 1'b1;
    end
    active = slcd_pkg::ComIdxW'(phase_nxt >> 1);
    odd    = phase_nxt[0];
    word   = frame[active];

    for (int c = 0; c < slcd_pkg::NumCommons; c++) begin
      if (32'(active) == c) begin
        com_drive_nxt[2*c +: 2] = odd ? slcd_pkg::LVL_FULL : slcd_pkg::LVL_GND;
      end else begin
        com_drive_nxt[2*c +: 2] = odd ? slcd_pkg::LVL_THIRD : slcd_pkg::LVL_TWO_THIRDS;
      end
    end

    for (int s = 0; s < slcd_pkg::NumSegments; s++) begin
      if (word[s]) begin
        seg_drive_nxt[2*s +: 2] = odd ? slcd_pkg::LVL_GND : slcd_pkg::LVL_FULL;
      end else begin
        seg_drive_nxt[2*s +: 2] = odd ? slcd_pkg::LVL_TWO_THIRDS : slcd_pkg::LVL_THIRD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (tick_fire) begin
        phase_r     <= phase_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick_fire) begin
      com_drive_r  <= com_drive_nxt;
      seg_drive_r  <= seg_drive_nxt;
      scan_phase_r <= phase_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.com_drive  = com_drive_r;
  assign out_ch.seg_drive  = seg_drive_r;
  assign out_ch.scan_phase = scan_phase_r;

endmodule

/* rtl/core/segment_lcd_mux_driver.sv */
// Segment LCD multiplex driver, 4 commons by 16 segments, 1/3 bias.
// A tick word with the display on goes through the input register, then the output register.
// Throughput: one request word per cycle; the output register only stalls input when full.
// Stages: input register (hundreds split), then buffer update or phase advance into
// the output register. Reset clears buffer, phase, enable and both valid flags at once.
module segment_lcd_mux_driver (
  input  logic                           clk,
  input  logic                           rst_n,
  slcd_in_if.sink                        in_ch,
  slcd_out_if.source                     out_ch,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [slcd_pkg::CfgAddrW-1:0]  cfg_paddr,
  input  logic [slcd_pkg::CfgDataW-1:0]  cfg_pwdata,
  output logic [slcd_pkg::CfgDataW-1:0]  cfg_prdata,
  output logic                           cfg_pready
);

  logic             display_enable;
  logic             item_valid;
  slcd_pkg::item_t  item;
  slcd_pkg::frame_t frame;
  logic             out_free;
  logic             makes_word;
  logic             fire;

  // a tick with the display on needs room in the output register
  assign makes_word = (item.req == slcd_pkg::REQ_TICK) && display_enable;
  assign fire       = item_valid && (!makes_word || out_free);

  slcd_cfg u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready),
    .display_enable (display_enable)
  );

  slcd_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .take       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  slcd_frame u_frame (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item),
    .frame (frame)
  );

  slcd_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .tick_fire (fire && makes_word),
    .frame     (frame),
    .out_free  (out_free),
    .out_ch    (out_ch)
  );

endmodule
